// ----- rtl/core/qpd_pkg.sv -----
// ----------------------------------------------------------------------------
// qpd_pkg
// Shared types and character codes for the quoted-printable decoder.
// ----------------------------------------------------------------------------
package qpd_pkg;

    typedef enum logic [2:0] {
        MODE_PLAIN  = 3'd0,
        MODE_ESC    = 3'd1,
        MODE_HEX2   = 3'd2,
        MODE_SOFTWS = 3'd3,
        MODE_DROP   = 3'd4,
        MODE_ERROR  = 3'd5
    } t_mode;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       in_last;
    } t_in_word;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       out_valid;
        logic       malformed;
        logic       out_last;
    } t_out_word;

    localparam logic [7:0] CH_TAB     = 8'd9;
    localparam logic [7:0] CH_LF      = 8'd10;
    localparam logic [7:0] CH_CR      = 8'd13;
    localparam logic [7:0] CH_SPACE   = 8'd32;
    localparam logic [7:0] CH_BANG    = 8'd33;
    localparam logic [7:0] CH_LT      = 8'd60;
    localparam logic [7:0] CH_EQUALS  = 8'd61;
    localparam logic [7:0] CH_GT      = 8'd62;
    localparam logic [7:0] CH_TILDE   = 8'd126;
    localparam logic [7:0] CH_DIGIT_0 = 8'd48;
    localparam logic [7:0] CH_DIGIT_9 = 8'd57;
    localparam logic [7:0] CH_UPPER_A = 8'd65;
    localparam logic [7:0] CH_UPPER_F = 8'd70;

endpackage

// ----- rtl/core/qpd_step.sv -----
// ----------------------------------------------------------------------------
// qpd_step
// Combinational decode of one encoded byte against the current mode.
// ----------------------------------------------------------------------------
module qpd_step
    import qpd_pkg::*;
(
    input  t_mode      i_mode,
    input  logic [3:0] i_nibble,
    input  t_in_word   i_word,
    output t_mode      o_mode,
    output logic [3:0] o_nibble,
    output t_out_word  o_word
);

    logic [7:0] b;
    logic       is_pass;
    logic       is_cr;
    logic       is_ws;
    logic       is_eq;
    logic       is_digit;
    logic       is_upper;
    logic       hex_ok;
    logic [3:0] hex_val;
    logic       err;
    t_mode      mid_mode;
    logic       open_at_end;

    assign b        = i_word.in_byte;
    assign is_cr    = (b == CH_CR);
    assign is_ws    = (b == CH_SPACE) || (b == CH_TAB);
    assign is_eq    = (b == CH_EQUALS);
    assign is_pass  = is_ws || is_cr || (b == CH_LF)
                   || ((b >= CH_BANG) && (b <= CH_LT))
                   || ((b >= CH_GT) && (b <= CH_TILDE));
    assign is_digit = (b >= CH_DIGIT_0) && (b <= CH_DIGIT_9);
    assign is_upper = (b >= CH_UPPER_A) && (b <= CH_UPPER_F);
    assign hex_ok   = is_digit || is_upper;
    assign hex_val  = is_digit ? 4'(b - CH_DIGIT_0) : 4'(b - CH_UPPER_A + 8'd10);

    // next state
    always_comb begin
        mid_mode = MODE_ERROR;
        unique case (i_mode)
            MODE_PLAIN: begin
                if (is_pass)      mid_mode = MODE_PLAIN;
                else if (is_eq)   mid_mode = MODE_ESC;
                else              mid_mode = MODE_ERROR;
            end
            MODE_ESC: begin
                if (hex_ok)       mid_mode = MODE_HEX2;
                else if (is_cr)   mid_mode = MODE_DROP;
                else if (is_ws)   mid_mode = MODE_SOFTWS;
                else              mid_mode = MODE_ERROR;
            end
            MODE_HEX2: begin
                mid_mode = hex_ok ? MODE_PLAIN : MODE_ERROR;
            end
            MODE_SOFTWS: begin
                if (is_cr)        mid_mode = MODE_DROP;
                else if (is_ws)   mid_mode = MODE_SOFTWS;
                else              mid_mode = MODE_ERROR;
            end
            MODE_DROP:  mid_mode = MODE_PLAIN;
            default:    mid_mode = MODE_ERROR;
        endcase

        o_mode   = i_word.in_last ? MODE_PLAIN : mid_mode;
        o_nibble = i_nibble;
        if (i_word.in_last) begin
            o_nibble = 4'd0;
        end else if ((i_mode == MODE_ESC) && hex_ok) begin
            o_nibble = hex_val;
        end
    end

    assign open_at_end = (mid_mode == MODE_ESC) || (mid_mode == MODE_HEX2)
                      || (mid_mode == MODE_SOFTWS);

    // outputs
    always_comb begin
        o_word = '0;
        err    = 1'b0;
        unique case (i_mode)
            MODE_PLAIN: begin
                if (is_pass) begin
                    o_word.out_byte  = b;
                    o_word.out_valid = 1'b1;
                end else if (!is_eq) begin
                    err = 1'b1;
                end
            end
            MODE_ESC:    err = !hex_ok && !is_cr && !is_ws;
            MODE_HEX2: begin
                if (hex_ok) begin
                    o_word.out_byte  = {i_nibble, hex_val};
                    o_word.out_valid = 1'b1;
                end else begin
                    err = 1'b1;
                end
            end
            MODE_SOFTWS: err = !is_cr && !is_ws;
            default:     err = 1'b0;
        endcase
        o_word.malformed = err || (i_word.in_last && open_at_end);
        o_word.out_last  = i_word.in_last;
    end

endmodule

// ----- rtl/core/quoted_printable_decoder.sv -----
// ----------------------------------------------------------------------------
// quoted_printable_decoder
// Quoted-printable stream decoder, one encoded byte in, one result word out.
// ----------------------------------------------------------------------------
// The input channel carries one encoded byte and an end-of-text flag per
// word; the output channel carries exactly one result word per input word:
// decoded byte with its valid flag, a malformed flag and the end flag.
// A word is taken on a rising edge with valid high and stall low.
// A word passes an input register, then the decode logic and the
// mode update, then the result register that drives the output port.
// Throughput is one word per cycle while the receiver does not stall,
// set by the mode loop around the decode logic.
// Reset (synchronous, active low) empties both registers and returns the
// decoder to plain text mode.
// When the receiver stalls, the result register holds its word; the input
// register keeps taking a word until it is also full, and from then on
// o_in_stall follows i_out_stall, so no word is lost or repeated.
// The word marked last always leaves the decoder in plain text mode.
// ----------------------------------------------------------------------------
module quoted_printable_decoder
    import qpd_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_word  i_in_data,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_word o_out_data
);

    logic       r_s1_valid;
    t_in_word   r_s1_data;
    logic       r_out_valid;
    t_out_word  r_out_data;
    t_mode      r_mode;
    logic [3:0] r_nibble;

    t_mode      n_mode;
    logic [3:0] n_nibble;
    t_out_word  n_out_data;

    logic       s1_go;
    logic       in_take;

    assign s1_go      = r_s1_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_s1_valid && !s1_go;
    assign in_take    = i_in_valid && !o_in_stall;

    qpd_step u_step (
        .i_mode   (r_mode),
        .i_nibble (r_nibble),
        .i_word   (r_s1_data),
        .o_mode   (n_mode),
        .o_nibble (n_nibble),
        .o_word   (n_out_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_mode      <= MODE_PLAIN;
            r_nibble    <= 4'd0;
        end else begin
            if (in_take) begin
                r_s1_valid <= 1'b1;
            end else if (s1_go) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_go) begin
                r_out_valid <= 1'b1;
                r_mode      <= n_mode;
                r_nibble    <= n_nibble;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_s1_data <= i_in_data;
        end
        if (s1_go) begin
            r_out_data <= n_out_data;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

// ----- rtl/core/qpd_checker.sv -----
// ----------------------------------------------------------------------------
// qpd_checker
// Port-level checks for the quoted-printable decoder, bound to the top level.
// ----------------------------------------------------------------------------
module qpd_checker
    import qpd_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_in_valid,
    input logic      o_in_stall,
    input t_in_word  i_in_data,
    input logic      o_out_valid,
    input logic      i_out_stall,
    input t_out_word o_out_data
);

    a_hold_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("result word changed while stalled");

    a_no_byte_on_error: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.out_valid |-> !o_out_data.malformed)
        else $error("decoded byte and malformed on the same word");

    a_empty_byte_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_data.out_valid |-> (o_out_data.out_byte == 8'd0))
        else $error("nonzero byte without out_valid");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && !o_in_stall)
        else $error("pipeline not empty after reset");

endmodule

bind quoted_printable_decoder qpd_checker u_qpd_checker (.*);
